// ===== rtl/imi_pkg.sv =====
package imi_pkg;

   localparam int MAX_WINDOW = 64;
   localparam int SLOT_BITS  = $clog2(MAX_WINDOW);
   localparam int LEN_BITS   = 7;
   localparam int PRICE_BITS = 32;
   localparam int DELTA_BITS = PRICE_BITS + 1;
   localparam int SUM_BITS   = 40;
   localparam int QUO_BITS   = 15;
   localparam int NUM_BITS   = SUM_BITS + QUO_BITS;
   localparam int DIV_STEPS  = QUO_BITS;
   localparam int STEP_BITS  = $clog2(DIV_STEPS);

   localparam logic [LEN_BITS-1:0] LEN_RESET = LEN_BITS'(14);
   localparam logic [LEN_BITS-1:0] LEN_MIN   = LEN_BITS'(2);
   localparam logic [LEN_BITS-1:0] LEN_MAX   = LEN_BITS'(MAX_WINDOW);

   typedef struct packed {
      logic signed [PRICE_BITS-1:0] open_price;
      logic signed [PRICE_BITS-1:0] close_price;
      logic                         last_of_series;
   } imi_req_type;

   typedef struct packed {
      logic [QUO_BITS-1:0] index_value;
      logic                zero_range;
   } imi_rsp_type;

   typedef struct packed {
      logic capture;
      logic update;
      logic clear;
      logic load;
      logic step;
      logic emit;
   } imi_cmd_type;

   typedef struct packed {
      logic last;
      logic result_due;
      logic out_free;
   } imi_status_type;

endpackage

// ===== rtl/imi_control.sv =====
module imi_control (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  imi_pkg::imi_status_type status,
   output imi_pkg::imi_cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_LOAD,
      ST_DIVIDE,
      ST_RESULT
   } state_type;

   state_type                       state_ff, state_in;
   logic                            ready_ff, ready_in;
   logic [imi_pkg::STEP_BITS-1:0]   step_ff, step_in;
   logic                            accept;

   assign req_ready = ready_ff;
   assign accept    = req_valid & ready_ff;

   always_comb begin
      state_in    = state_ff;
      ready_in    = ready_ff;
      step_in     = step_ff;
      cmd         = '0;
      cmd.capture = accept;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_UPDATE;
               ready_in = 1'b0;
            end
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            if (status.result_due) begin
               state_in = ST_LOAD;
            end else begin
               cmd.clear = status.last;
               state_in  = ST_IDLE;
               ready_in  = 1'b1;
            end
         end
         ST_LOAD: begin
            cmd.load = 1'b1;
            step_in  = '0;
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            cmd.step = 1'b1;
            step_in  = step_ff + 1'b1;
            if (step_ff == imi_pkg::STEP_BITS'(imi_pkg::DIV_STEPS - 1)) begin
               state_in = ST_RESULT;
            end
         end
         ST_RESULT: begin
            if (status.out_free) begin
               cmd.emit  = 1'b1;
               cmd.clear = status.last;
               state_in  = ST_IDLE;
               ready_in  = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
            ready_in = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ready_ff <= 1'b1;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         ready_ff <= ready_in;
         step_ff  <= step_in;
      end
   end

endmodule

// ===== rtl/imi_datapath.sv =====
module imi_datapath (
   input  logic                               clock,
   input  logic                               reset,
   input  imi_pkg::imi_req_type               req_payload,
   input  logic                               csr_write_enable,
   input  logic [imi_pkg::LEN_BITS-1:0]       csr_write_data,
   input  logic                               rsp_ready,
   output logic                               rsp_valid,
   output imi_pkg::imi_rsp_type               rsp_payload,
   input  imi_pkg::imi_cmd_type               cmd,
   output imi_pkg::imi_status_type            status
);

   localparam int SB = imi_pkg::SUM_BITS;
   localparam int NB = imi_pkg::NUM_BITS;
   localparam int DB = imi_pkg::DELTA_BITS;
   localparam int LB = imi_pkg::LEN_BITS;

   logic signed [DB-1:0]            hist_mem_ff [imi_pkg::MAX_WINDOW];
   logic signed [DB-1:0]            old_ff;
   logic signed [DB-1:0]            delta_ff, delta_in;
   logic                            last_ff;
   logic [LB-1:0]                   length_ff, length_in;
   logic [SB-1:0]                   up_ff, up_in;
   logic [SB-1:0]                   down_ff, down_in;
   logic [imi_pkg::SLOT_BITS-1:0]   slot_ff, slot_in;
   logic [LB-1:0]                   fill_ff, fill_in;
   logic [NB-1:0]                   rem_ff, rem_in;
   logic [NB-1:0]                   div_ff, div_in;
   logic [imi_pkg::QUO_BITS-1:0]    quo_ff, quo_in;
   logic                            zero_ff, zero_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   imi_pkg::imi_rsp_type            rsp_ff, rsp_in;

   logic [LB-1:0]                   period;
   logic                            full;
   logic [LB-1:0]                   fill_next;
   logic [LB-1:0]                   slot_inc;
   logic [SB-1:0]                   new_up, new_down, old_up, old_down;
   logic [SB-1:0]                   total;
   logic                            ge;

   always_comb begin
      if (length_ff < imi_pkg::LEN_MIN) begin
         period = imi_pkg::LEN_MIN;
      end else if (length_ff > imi_pkg::LEN_MAX) begin
         period = imi_pkg::LEN_MAX;
      end else begin
         period = length_ff;
      end
   end

   assign full      = (fill_ff >= period);
   assign fill_next = full ? fill_ff : fill_ff + 1'b1;
   assign slot_inc  = LB'(slot_ff) + 1'b1;
   assign total     = up_ff + down_ff;
   assign ge        = (rem_ff >= div_ff);

   assign delta_in = {req_payload.close_price[imi_pkg::PRICE_BITS-1], req_payload.close_price}
                   - {req_payload.open_price[imi_pkg::PRICE_BITS-1], req_payload.open_price};

   always_comb begin
      if (delta_ff > 0) begin
         new_up   = SB'($unsigned(delta_ff));
         new_down = '0;
      end else begin
         new_up   = '0;
         new_down = SB'($unsigned(-delta_ff));
      end
      if (!full) begin
         old_up   = '0;
         old_down = '0;
      end else if (old_ff > 0) begin
         old_up   = SB'($unsigned(old_ff));
         old_down = '0;
      end else begin
         old_up   = '0;
         old_down = SB'($unsigned(-old_ff));
      end
   end

   always_comb begin
      length_in    = length_ff;
      up_in        = up_ff;
      down_in      = down_ff;
      slot_in      = slot_ff;
      fill_in      = fill_ff;
      rem_in       = rem_ff;
      div_in       = div_ff;
      quo_in       = quo_ff;
      zero_in      = zero_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;

      if (cmd.update) begin
         up_in   = up_ff - old_up + new_up;
         down_in = down_ff - old_down + new_down;
         slot_in = (slot_inc >= period) ? '0 : slot_inc[imi_pkg::SLOT_BITS-1:0];
         fill_in = fill_next;
      end
      if (cmd.load) begin
         rem_in  = (NB'(up_ff) << 14) + (NB'(up_ff) << 13) + (NB'(up_ff) << 10);
         div_in  = NB'(total) << (imi_pkg::QUO_BITS - 1);
         quo_in  = '0;
         zero_in = (total == '0);
      end
      if (cmd.step) begin
         if (ge) begin
            rem_in = rem_ff - div_ff;
         end
         quo_in = {quo_ff[imi_pkg::QUO_BITS-2:0], ge};
         div_in = div_ff >> 1;
      end
      if (cmd.emit) begin
         rsp_in.index_value = zero_ff ? '0 : quo_ff;
         rsp_in.zero_range  = zero_ff;
         rsp_valid_in       = 1'b1;
      end
      if (csr_write_enable) begin
         length_in = csr_write_data;
      end
      if (cmd.clear || csr_write_enable) begin
         up_in   = '0;
         down_in = '0;
         slot_in = '0;
         fill_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff    <= imi_pkg::LEN_RESET;
         up_ff        <= '0;
         down_ff      <= '0;
         slot_ff      <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         length_ff    <= length_in;
         up_ff        <= up_in;
         down_ff      <= down_in;
         slot_ff      <= slot_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      div_ff  <= div_in;
      quo_ff  <= quo_in;
      zero_ff <= zero_in;
      rsp_ff  <= rsp_in;
      if (cmd.capture) begin
         delta_ff <= delta_in;
         last_ff  <= req_payload.last_of_series;
      end
   end

   always_ff @(posedge clock) begin
      old_ff <= hist_mem_ff[slot_ff];
      if (cmd.update) begin
         hist_mem_ff[slot_ff] <= delta_ff;
      end
   end

   assign status.last       = last_ff;
   assign status.result_due = (fill_next >= period);
   assign status.out_free   = ~rsp_valid_ff | rsp_ready;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// ===== rtl/intraday_momentum_index_unit.sv =====
// Intraday momentum index over a sliding window of bars.
// req channel: one transaction per bar (open_price, close_price,
//   last_of_series). req_ready is high while the unit is idle.
// rsp channel: one transaction (index_value, zero_range) per bar once the
//   window holds window_length deltas; earlier bars give no transaction.
// csr_write_enable/csr_write_data set window_length (clamped to 2..64) and
//   clear the window; write only while the unit is idle.
// Sequence: a bar with a result passes through update, operand load, a
//   restoring divider, output load and idle before the next acceptance;
//   req_ready and rsp_valid rise together. A bar without a result goes
//   from update straight back to idle. The divider sets the rate.
// last_of_series clears the window and sums after that bar's update/result.
// Reset: window empty, sums zero, window_length 14, rsp_valid low.
// Stall: the result sits in the output register, and the next bar is
//   accepted and processed meanwhile; the unit only waits in its output
//   step if the register is still occupied.
module intraday_momentum_index_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  imi_pkg::imi_req_type               req_payload,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output imi_pkg::imi_rsp_type               rsp_payload,
   input  logic                               csr_write_enable,
   input  logic [imi_pkg::LEN_BITS-1:0]       csr_write_data
);

   imi_pkg::imi_cmd_type    cmd;
   imi_pkg::imi_status_type status;

   imi_control u_control (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   imi_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_payload      (req_payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp_ready        (rsp_ready),
      .rsp_valid        (rsp_valid),
      .rsp_payload      (rsp_payload),
      .cmd              (cmd),
      .status           (status)
   );

endmodule
